// ----- hw/rtl/tile_atlas_pixel_renderer_assert.svh -----
// Assertion macros for the tile atlas pixel renderer.
// Included by the top level; needs nothing else.
`ifndef TILE_ATLAS_PIXEL_RENDERER_ASSERT_SVH
`define TILE_ATLAS_PIXEL_RENDERER_ASSERT_SVH

// a in this cycle implies b in the same cycle
`define TAP_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("tile atlas renderer: same-cycle check failed");

// a in this cycle implies b in the next cycle
`define TAP_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("tile atlas renderer: next-cycle check failed");

`endif

// ----- hw/rtl/tap_pkg.sv -----
// Shared types and constants of the tile atlas pixel renderer.
// No dependencies; used by every module of the block.
package tap_pkg;

  localparam int TILE_W      = 10;
  localparam int ADDR_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int PX_X_W      = 8;
  localparam int PX_Y_W      = 10;
  localparam int PAL_BYTES   = 768;
  localparam int PAL_ROWS    = 256;
  localparam int PAL_CH      = 3;
  localparam int PIXELS      = 64;
  localparam int QUEUE_DEPTH = 2;   // power of two
  localparam int CFG_IDX_W   = 1;

  localparam int TILES_PER_ROW_DEF = 16;
  localparam int TILE_LIMIT_DEF    = 1024;

  localparam logic [BYTE_W-1:0] MAGENTA_RB = 8'd252;
  localparam logic [BYTE_W-1:0] ALPHA_ON   = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_EN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECONDARY_EN = 1'd1;

  typedef enum logic [1:0] {
    OP_LOAD_GFX = 2'd0,
    OP_LOAD_PRI = 2'd1,
    OP_LOAD_SEC = 2'd2,
    OP_DRAW     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_NOP  = 3'd0,
    K_GFX  = 3'd1,
    K_PRI  = 3'd2,
    K_SEC  = 3'd3,
    K_DRAW = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] gfx_addr;
    logic [BYTE_W-1:0] value;
    logic [7:0]        pal_index;
    logic [1:0]        pal_chan;
    logic [TILE_W-1:0] tile;
    logic [TILE_W-1:0] tile_q;     // tile / TILES_PER_ROW
    logic              quad_x;
    logic              quad_y;
    logic              flip_x;
    logic              flip_y;
    logic [ADDR_W-1:0] base;
  } entry_t;

  typedef struct packed {
    logic pri_en;
    logic sec_en;
  } cfg_t;

  typedef struct packed {
    logic clearing;
    logic pipe_busy;
  } back_status_t;

endpackage

// ----- hw/rtl/tap_front.sv -----
// Front end: accepts a command word and classifies it into a queue entry.
// Depends on tap_pkg.
module tap_front #(
  parameter int TILES_PER_ROW = tap_pkg::TILES_PER_ROW_DEF,
  parameter int TILE_LIMIT    = tap_pkg::TILE_LIMIT_DEF
) (
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic [1:0]                   operation_i,
  input  logic [tap_pkg::ADDR_W-1:0]   address_i,
  input  logic [tap_pkg::BYTE_W-1:0]   load_value_i,
  input  logic [tap_pkg::TILE_W-1:0]   tile_number_i,
  input  logic                         quadrant_x_i,
  input  logic                         quadrant_y_i,
  input  logic [tap_pkg::ADDR_W-1:0]   descriptor_i,
  output logic                         push_o,
  output tap_pkg::entry_t              entry_o
);

  // tile / TILES_PER_ROW by reciprocal; error stays below one count for tile < 1024
  localparam int RecipShift = 20;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = tap_pkg::TILE_W + RecipW;
  localparam longint Recip  = ((64'd1 << RecipShift) + TILES_PER_ROW - 1) / TILES_PER_ROW;

  logic [ProdW-1:0] q_prod;
  logic [20:0]      pal_prod;
  logic             tile_ok;

  assign q_prod = ProdW'(tile_number_i) * ProdW'(Recip);

  // addr / 3 as addr * 683 / 2048, exact below 768; channel is what is left over
  assign pal_prod = 21'(address_i[9:0]) * 21'd683;

  assign tile_ok = 32'(tile_number_i) < 32'(TILE_LIMIT);
  assign push_o  = start_i && !busy_i;

  always_comb begin
    entry_o           = '0;
    entry_o.gfx_addr  = address_i;
    entry_o.value     = load_value_i;
    entry_o.pal_index = pal_prod[18:11];
    entry_o.pal_chan  = 2'(address_i[9:0] - 10'(pal_prod[18:11]) * 10'd3);
    entry_o.tile      = tile_number_i;
    entry_o.tile_q    = q_prod[RecipShift +: tap_pkg::TILE_W];
    entry_o.quad_x    = quadrant_x_i;
    entry_o.quad_y    = quadrant_y_i;
    entry_o.flip_x    = descriptor_i[1];
    entry_o.flip_y    = descriptor_i[0];
    entry_o.base      = {descriptor_i[14:2], 3'b000};
    case (tap_pkg::op_e'(operation_i))
      tap_pkg::OP_LOAD_GFX: entry_o.kind = tap_pkg::K_GFX;
      tap_pkg::OP_LOAD_PRI: entry_o.kind = (32'(address_i) < tap_pkg::PAL_BYTES) ?
                                           tap_pkg::K_PRI : tap_pkg::K_NOP;
      tap_pkg::OP_LOAD_SEC: entry_o.kind = (32'(address_i) < tap_pkg::PAL_BYTES) ?
                                           tap_pkg::K_SEC : tap_pkg::K_NOP;
      tap_pkg::OP_DRAW:     entry_o.kind = tile_ok ? tap_pkg::K_DRAW : tap_pkg::K_NOP;
      default:              entry_o.kind = tap_pkg::K_NOP;
    endcase
  end

endmodule

// ----- hw/rtl/tap_queue.sv -----
// Short command queue between the front end and the draw engine.
// Depends on tap_pkg.
module tap_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tap_pkg::entry_t entry_i,
  input  logic            pop_i,
  output tap_pkg::entry_t head_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int Depth = tap_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tap_pkg::entry_t slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ----- hw/rtl/tap_back.sv -----
// Draw engine: executes loads into the stores and walks a minitile,
// one pixel per cycle through graphics read, palette read and merge. Depends on tap_pkg.
module tap_back #(
  parameter int TILES_PER_ROW = tap_pkg::TILES_PER_ROW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tap_pkg::cfg_t               cfg_i,
  input  tap_pkg::entry_t             head_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output tap_pkg::back_status_t       status_o,
  output logic                        valid_o,
  output logic [tap_pkg::PX_X_W-1:0]  pixel_x_o,
  output logic [tap_pkg::PX_Y_W-1:0]  pixel_y_o,
  output logic [tap_pkg::BYTE_W-1:0]  red_o,
  output logic [tap_pkg::BYTE_W-1:0]  green_o,
  output logic [tap_pkg::BYTE_W-1:0]  blue_o,
  output logic [tap_pkg::BYTE_W-1:0]  alpha_o,
  output logic                        last_pixel_o
);

  localparam int MulW  = tap_pkg::TILE_W + $clog2(TILES_PER_ROW + 1);
  localparam int RowW  = $clog2(tap_pkg::PAL_ROWS);
  localparam int PixW  = $clog2(tap_pkg::PIXELS);
  localparam int BW    = tap_pkg::BYTE_W;

  // clearing pass over the palette rows after reset
  logic            clearing_q;
  logic [RowW-1:0] clr_cnt_q;

  // draw sequencer
  logic                        draw_active_q;
  logic [PixW-1:0]             cnt_q;
  logic                        flip_x_q, flip_y_q;
  logic [tap_pkg::ADDR_W-1:0]  base_q;
  logic [tap_pkg::PX_X_W-1:0]  col0_q;
  logic [tap_pkg::PX_Y_W-1:0]  row0_q;
  logic [MulW-1:0]             rem_full;
  logic [2:0]                  col, row, fx, fy;
  logic [tap_pkg::ADDR_W-1:0]  src;

  // pipeline
  logic                        s1_valid_q, s2_valid_q, out_valid_q;
  logic [tap_pkg::PX_X_W-1:0]  s1_x_q, s2_x_q;
  logic [tap_pkg::PX_Y_W-1:0]  s1_y_q, s2_y_q;
  logic                        s1_last_q, s2_last_q;
  logic [BW-1:0]               gfx_rd_q, idx_q;

  // stores
  logic [BW-1:0] gfx_mem [2**tap_pkg::ADDR_W];
  logic [BW-1:0] pri_mem [tap_pkg::PAL_CH][tap_pkg::PAL_ROWS];
  logic [BW-1:0] sec_mem [tap_pkg::PAL_CH][tap_pkg::PAL_ROWS];
  logic [BW-1:0] pri_rd_q [tap_pkg::PAL_CH];
  logic [BW-1:0] sec_rd_q [tap_pkg::PAL_CH];

  logic            pop;
  logic            wr_gfx, wr_pri, wr_sec;
  logic [RowW-1:0] pal_row;
  logic [BW-1:0]   pal_data;

  // merge
  logic [BW-1:0] prim [tap_pkg::PAL_CH];
  logic [BW-1:0] mix  [tap_pkg::PAL_CH];
  logic          p_mag, s_mag, use_s;

  assign pop   = !empty_i && !clearing_q && !draw_active_q;
  assign pop_o = pop;

  assign wr_gfx   = pop && (head_i.kind == tap_pkg::K_GFX);
  assign wr_pri   = pop && (head_i.kind == tap_pkg::K_PRI);
  assign wr_sec   = pop && (head_i.kind == tap_pkg::K_SEC);
  assign pal_row  = clearing_q ? clr_cnt_q : head_i.pal_index;
  assign pal_data = clearing_q ? '0 : {head_i.value[BW-3:0], 2'b00};

  assign rem_full = MulW'(head_i.tile) - MulW'(head_i.tile_q) * MulW'(TILES_PER_ROW);

  assign col = cnt_q[2:0];
  assign row = cnt_q[5:3];
  assign fx  = flip_x_q ? ~col : col;
  assign fy  = flip_y_q ? ~row : row;
  assign src = base_q + {10'b0, fy, fx};

  assign status_o.clearing  = clearing_q;
  assign status_o.pipe_busy = draw_active_q || s1_valid_q || s2_valid_q || out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q    <= 1'b1;
      clr_cnt_q     <= '0;
      draw_active_q <= 1'b0;
      cnt_q         <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + RowW'(1);
        if (clr_cnt_q == RowW'(tap_pkg::PAL_ROWS - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (pop && head_i.kind == tap_pkg::K_DRAW) begin
        draw_active_q <= 1'b1;
        cnt_q         <= '0;
      end else if (draw_active_q) begin
        cnt_q <= cnt_q + PixW'(1);
        if (cnt_q == PixW'(tap_pkg::PIXELS - 1)) begin
          draw_active_q <= 1'b0;
        end
      end
      s1_valid_q  <= draw_active_q;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // draw parameters and pipeline payload
  always_ff @(posedge clk_i) begin
    if (pop && head_i.kind == tap_pkg::K_DRAW) begin
      flip_x_q <= head_i.flip_x;
      flip_y_q <= head_i.flip_y;
      base_q   <= head_i.base;
      col0_q   <= {rem_full[3:0], head_i.quad_x, 3'b000};
      row0_q   <= {head_i.tile_q[5:0], head_i.quad_y, 3'b000};
    end
    s1_x_q    <= col0_q + {5'b0, col};
    s1_y_q    <= row0_q + {7'b0, row};
    s1_last_q <= (cnt_q == PixW'(tap_pkg::PIXELS - 1));
    s2_x_q    <= s1_x_q;
    s2_y_q    <= s1_y_q;
    s2_last_q <= s1_last_q;
    idx_q     <= gfx_rd_q;
  end

  // graphics store
  always_ff @(posedge clk_i) begin
    if (wr_gfx) begin
      gfx_mem[head_i.gfx_addr] <= head_i.value;
    end
    gfx_rd_q <= gfx_mem[src];
  end

  // palette stores, one memory per channel
  for (genvar k = 0; k < tap_pkg::PAL_CH; k++) begin : g_pal
    always_ff @(posedge clk_i) begin
      if (clearing_q || (wr_pri && head_i.pal_chan == 2'(k))) begin
        pri_mem[k][pal_row] <= pal_data;
      end
      if (clearing_q || (wr_sec && head_i.pal_chan == 2'(k))) begin
        sec_mem[k][pal_row] <= pal_data;
      end
      pri_rd_q[k] <= pri_mem[k][gfx_rd_q];
      sec_rd_q[k] <= sec_mem[k][gfx_rd_q];
    end
  end

  always_comb begin
    for (int k = 0; k < tap_pkg::PAL_CH; k++) begin
      prim[k] = cfg_i.pri_en ? pri_rd_q[k] : '0;
    end
    p_mag = (prim[0] == tap_pkg::MAGENTA_RB) && (prim[1] == '0) &&
            (prim[2] == tap_pkg::MAGENTA_RB);
    s_mag = (sec_rd_q[0] == tap_pkg::MAGENTA_RB) && (sec_rd_q[1] == '0) &&
            (sec_rd_q[2] == tap_pkg::MAGENTA_RB);
    // lower indices: secondary fills primary magenta; upper: secondary wins unless magenta
    use_s = cfg_i.sec_en && (idx_q[BW-1] ? !s_mag : p_mag);
    for (int k = 0; k < tap_pkg::PAL_CH; k++) begin
      mix[k] = use_s ? sec_rd_q[k] : prim[k];
    end
  end

  always_ff @(posedge clk_i) begin
    pixel_x_o    <= s2_x_q;
    pixel_y_o    <= s2_y_q;
    red_o        <= mix[0];
    green_o      <= mix[1];
    blue_o       <= mix[2];
    alpha_o      <= (idx_q != '0) ? tap_pkg::ALPHA_ON : '0;
    last_pixel_o <= s2_last_q;
  end

  assign valid_o = out_valid_q;

endmodule

// ----- hw/rtl/tile_atlas_pixel_renderer.sv -----
// Tile atlas pixel renderer, top level.
// Depends on tap_pkg, tap_front, tap_queue, tap_back and the assertion header.
//
// Use:
//   Command channel: a word is taken at a rising edge with start_i high and
//   busy_o low. Operation 0 writes a graphics byte, 1 and 2 write a primary
//   or secondary palette component (stored times four), 3 draws an 8x8
//   minitile. Commands pass through a two-entry queue to the draw engine.
//   Result channel: valid_o strobes for one cycle per pixel; the receiver
//   cannot stall, so it must take every pixel as it comes.
//   Config port: cfg_we_i writes bit 0 of cfg_wdata_i into the register at
//   cfg_idx_i (0 primary enable, 1 secondary enable). The user must write
//   the registers only while idle; nothing in the block enforces this.
// Timing:
//   Loads retire as they leave the queue. A draw holds the engine until its
//   last pixel is issued, and only then is the next word picked up. A word
//   passes the queue, draw registers, graphics read, palette read and output
//   register. One graphics read per cycle sets the rate of a draw.
// Reset:
//   Both enables go to 1. The palettes are cleared by a pass over every row
//   after reset, one row per cycle, with busy_o high. Graphics bytes hold
//   no defined value until written.
module tile_atlas_pixel_renderer #(
  parameter int TILES_PER_ROW = tap_pkg::TILES_PER_ROW_DEF,
  parameter int TILE_LIMIT    = tap_pkg::TILE_LIMIT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    operation_i,
  input  logic [tap_pkg::ADDR_W-1:0]    address_i,
  input  logic [tap_pkg::BYTE_W-1:0]    load_value_i,
  input  logic [tap_pkg::TILE_W-1:0]    tile_number_i,
  input  logic                          quadrant_x_i,
  input  logic                          quadrant_y_i,
  input  logic [tap_pkg::ADDR_W-1:0]    descriptor_i,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [tap_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [0:0]                    cfg_wdata_i,
  // pixel channel
  output logic                          valid_o,
  output logic [tap_pkg::PX_X_W-1:0]    pixel_x_o,
  output logic [tap_pkg::PX_Y_W-1:0]    pixel_y_o,
  output logic [tap_pkg::BYTE_W-1:0]    red_o,
  output logic [tap_pkg::BYTE_W-1:0]    green_o,
  output logic [tap_pkg::BYTE_W-1:0]    blue_o,
  output logic [tap_pkg::BYTE_W-1:0]    alpha_o,
  output logic                          last_pixel_o
);

`include "tile_atlas_pixel_renderer_assert.svh"

  tap_pkg::cfg_t         cfg_q, cfg_d;
  tap_pkg::entry_t       fe_entry, head;
  tap_pkg::back_status_t back_status;
  logic                  push, pop, q_empty, q_full;

  // config registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        tap_pkg::CFG_PRIMARY_EN:   cfg_d.pri_en = cfg_wdata_i[0];
        tap_pkg::CFG_SECONDARY_EN: cfg_d.sec_en = cfg_wdata_i[0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pri_en: 1'b1, sec_en: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // hold off commands while the queue is full or the palettes are clearing
  assign busy_o = q_full || back_status.clearing;

  tap_front #(
    .TILES_PER_ROW (TILES_PER_ROW),
    .TILE_LIMIT    (TILE_LIMIT)
  ) u_front (
    .start_i       (start_i),
    .busy_i        (busy_o),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .load_value_i  (load_value_i),
    .tile_number_i (tile_number_i),
    .quadrant_x_i  (quadrant_x_i),
    .quadrant_y_i  (quadrant_y_i),
    .descriptor_i  (descriptor_i),
    .push_o        (push),
    .entry_o       (fe_entry)
  );

  tap_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (fe_entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  tap_back #(
    .TILES_PER_ROW (TILES_PER_ROW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .empty_i      (q_empty),
    .pop_o        (pop),
    .status_o     (back_status),
    .valid_o      (valid_o),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .last_pixel_o (last_pixel_o)
  );

  // no draw traffic while the palettes are being cleared
  `TAP_ASSERT_SAME(a_clear_quiet, clk_i, rst_ni, back_status.clearing, !back_status.pipe_busy)
  // a minitile leaves as an unbroken burst of pixels
  `TAP_ASSERT_NEXT(a_burst, clk_i, rst_ni, valid_o && !last_pixel_o, valid_o)
  // the queue never overflows
  `TAP_ASSERT_SAME(a_no_overflow, clk_i, rst_ni, push, !q_full || pop)

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for tile_atlas_pixel_renderer: command words in, atlas pixels out.
// Depends on tap_pkg and the renderer RTL. A scoreboard class predicts every pixel
// from its own copy of the graphics store, both palettes and the two enables.

typedef struct {
  tap_pkg::op_e op;
  logic [15:0]  addr;
  logic [7:0]   value;
  logic [9:0]   tile;
  logic         qx;
  logic         qy;
  logic [15:0]  desc;
} cmd_word_t;

typedef struct {
  logic [7:0] px_x;
  logic [9:0] px_y;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_px;
} atlas_pixel_t;

class atlas_pixel_ledger;
  localparam logic [23:0] MAGENTA_RGB = 24'hFC00FC;

  logic [7:0]   gfx_mem [65536];
  logic [7:0]   pri_pal [768];
  logic [7:0]   sec_pal [768];
  bit           pri_en;
  bit           sec_en;
  atlas_pixel_t pixels_due [$];
  int unsigned  mismatches;

  function new();
    foreach (gfx_mem[i]) gfx_mem[i] = 8'd0;
    foreach (pri_pal[i]) begin
      pri_pal[i] = 8'd0;
      sec_pal[i] = 8'd0;
    end
    pri_en     = 1'b1;
    sec_en     = 1'b1;
    mismatches = 0;
  endfunction

  function void set_enables(bit pri, bit sec);
    pri_en = pri;
    sec_en = sec;
  endfunction

  // low indices fall back to secondary on magenta primary,
  // high indices keep primary only where secondary is magenta
  function logic [23:0] merged_rgb(logic [7:0] idx);
    int          b;
    logic [23:0] p;
    logic [23:0] s;
    b = 3 * int'(idx);
    p = pri_en ? {pri_pal[b], pri_pal[b+1], pri_pal[b+2]} : 24'd0;
    s = {sec_pal[b], sec_pal[b+1], sec_pal[b+2]};
    if (sec_en) begin
      if (idx < 8'd128) begin
        if (p == MAGENTA_RGB) p = s;
      end else if (s != MAGENTA_RGB) begin
        p = s;
      end
    end
    return p;
  endfunction

  function void take_word(cmd_word_t w);
    int           col0;
    int           row0;
    int           fx;
    int           fy;
    logic [15:0]  base;
    logic [15:0]  src;
    logic [7:0]   idx;
    logic [23:0]  rgb;
    atlas_pixel_t px;
    case (w.op)
      tap_pkg::OP_LOAD_GFX: gfx_mem[w.addr] = w.value;
      tap_pkg::OP_LOAD_PRI:
        if (w.addr < tap_pkg::PAL_BYTES) pri_pal[w.addr] = {w.value[5:0], 2'b00};
      tap_pkg::OP_LOAD_SEC:
        if (w.addr < tap_pkg::PAL_BYTES) sec_pal[w.addr] = {w.value[5:0], 2'b00};
      default: begin
        if (int'(w.tile) < tap_pkg::TILE_LIMIT_DEF) begin
          base = {w.desc[14:2], 3'b000};
          col0 = (int'(w.tile) % tap_pkg::TILES_PER_ROW_DEF) * 16 + int'(w.qx) * 8;
          row0 = (int'(w.tile) / tap_pkg::TILES_PER_ROW_DEF) * 16 + int'(w.qy) * 8;
          for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
              fy = w.desc[0] ? 7 - r : r;
              fx = w.desc[1] ? 7 - c : c;
              src = base + 16'(fy * 8 + fx);
              idx = gfx_mem[src];
              rgb = merged_rgb(idx);
              px.px_x    = 8'(col0 + c);
              px.px_y    = 10'(row0 + r);
              px.red     = rgb[23:16];
              px.green   = rgb[15:8];
              px.blue    = rgb[7:0];
              px.alpha   = (idx != 8'd0) ? 8'd255 : 8'd0;
              px.last_px = (r == 7) && (c == 7);
              pixels_due.push_back(px);
            end
          end
        end
      end
    endcase
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_pixel(atlas_pixel_t got);
    atlas_pixel_t want;
    if (pixels_due.size() == 0) begin
      mismatches++;
      $display("%0t: pixel (%0d,%0d) with no draw pending, expected none", $time,
               got.px_x, got.px_y);
      return;
    end
    want = pixels_due.pop_front();
    compare_field("pixel_x", 32'(want.px_x), 32'(got.px_x));
    compare_field("pixel_y", 32'(want.px_y), 32'(got.px_y));
    compare_field("red", 32'(want.red), 32'(got.red));
    compare_field("green", 32'(want.green), 32'(got.green));
    compare_field("blue", 32'(want.blue), 32'(got.blue));
    compare_field("alpha", 32'(want.alpha), 32'(got.alpha));
    compare_field("last_pixel", 32'(want.last_px), 32'(got.last_px));
  endfunction
endclass

module testbench;

  // headroom after the last pixel: queue, two reads and the merge register
  localparam int SETTLE_CYCLES = 8;
  localparam int TOTAL_WORDS   = 310;
  localparam int PHASES        = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  operation_i;
  logic [15:0] address_i;
  logic [7:0]  load_value_i;
  logic [9:0]  tile_number_i;
  logic        quadrant_x_i;
  logic        quadrant_y_i;
  logic [15:0] descriptor_i;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [0:0]  cfg_wdata_i;
  logic        valid_o;
  logic [7:0]  pixel_x_o;
  logic [9:0]  pixel_y_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        last_pixel_o;

  atlas_pixel_ledger ledger;

  // graphics bytes written so far; a draw never reads one that is not
  bit          gfx_written [65536];
  // descriptors whose 64-byte source window is fully written
  logic [15:0] filled_desc [$];
  int          words_sent;
  int          burst_left;

  // enable settings per random phase: both on, each off alone, both off, back on
  bit pri_plan [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  bit sec_plan [PHASES] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};

  tile_atlas_pixel_renderer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .load_value_i  (load_value_i),
    .tile_number_i (tile_number_i),
    .quadrant_x_i  (quadrant_x_i),
    .quadrant_y_i  (quadrant_y_i),
    .descriptor_i  (descriptor_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .alpha_o       (alpha_o),
    .last_pixel_o  (last_pixel_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Pixel monitor. Outputs are read in the active region of the rising edge,
  // so they hold the values of the cycle that edge closes.
  always @(posedge clk_i) begin : sample_pixels
    atlas_pixel_t got;
    if (rst_ni && valid_o) begin
      got.px_x    = pixel_x_o;
      got.px_y    = pixel_y_o;
      got.red     = red_o;
      got.green   = green_o;
      got.blue    = blue_o;
      got.alpha   = alpha_o;
      got.last_px = last_pixel_o;
      ledger.check_pixel(got);
    end
  end

  // Mostly a handful of hot indices so palette writes actually land on
  // drawn pixels; 0, 127, 128 and 255 sit at the merge and alpha boundaries.
  function automatic logic [7:0] hot_index();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 3));
    if (r < 8) return 8'(128 + $urandom_range(0, 3));
    if (r == 8) return $urandom_range(0, 1) ? 8'd127 : 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [9:0] pick_tile();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    return 10'($urandom_range(0, 1023));
  endfunction

  // op set to draw, every other field random; callers then set the ones the operation uses
  function automatic cmd_word_t blank_word();
    cmd_word_t w;
    w.op    = tap_pkg::OP_DRAW;
    w.addr  = 16'($urandom);
    w.value = 8'($urandom);
    w.tile  = 10'($urandom);
    w.qx    = 1'($urandom);
    w.qy    = 1'($urandom);
    w.desc  = 16'($urandom);
    return w;
  endfunction

  // Sender: bursts of random length, random gaps between them (sometimes none),
  // so gaps land on every phase of a 64-pixel draw. Inputs move at the falling
  // edge; the word is taken at the first rising edge with busy_o low.
  task automatic send_word(cmd_word_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk_i);
        start_i <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    start_i       <= 1'b1;
    operation_i   <= w.op;
    address_i     <= w.addr;
    load_value_i  <= w.value;
    tile_number_i <= w.tile;
    quadrant_x_i  <= w.qx;
    quadrant_y_i  <= w.qy;
    descriptor_i  <= w.desc;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    ledger.take_word(w);
    words_sent++;
  endtask

  task automatic load_gfx(logic [15:0] a, logic [7:0] v);
    cmd_word_t w;
    w = blank_word();
    w.op    = tap_pkg::OP_LOAD_GFX;
    w.addr  = a;
    w.value = v;
    send_word(w);
    gfx_written[a] = 1'b1;
  endtask

  task automatic load_pal(tap_pkg::op_e op, logic [15:0] a, logic [7:0] v);
    cmd_word_t w;
    w = blank_word();
    w.op    = op;
    w.addr  = a;
    w.value = v;
    send_word(w);
  endtask

  // Writes a magenta triple (252,0,252 after the times-four) to one palette
  // entry; spoil replaces one channel so near-misses are covered too.
  task automatic load_magenta(tap_pkg::op_e op, logic [7:0] idx, bit spoil);
    logic [7:0]  ch [3];
    logic [15:0] a;
    ch[0] = {2'($urandom), 6'h3F};
    ch[1] = {2'($urandom), 6'h00};
    ch[2] = {2'($urandom), 6'h3F};
    if (spoil) ch[$urandom_range(0, 2)] = 8'($urandom);
    a = 16'(3 * int'(idx));
    for (int k = 0; k < 3; k++) load_pal(op, a + 16'(k), ch[k]);
  endtask

  // Fills any unwritten byte of the source window first, then draws.
  task automatic draw_minitile(logic [9:0] tile, logic qx, logic qy, logic [15:0] desc);
    cmd_word_t   w;
    logic [15:0] base;
    logic [15:0] a;
    base = {desc[14:2], 3'b000};
    for (int k = 0; k < 64; k++) begin
      a = base + 16'(k);
      if (!gfx_written[a]) load_gfx(a, hot_index());
    end
    w = blank_word();
    w.op   = tap_pkg::OP_DRAW;
    w.tile = tile;
    w.qx   = qx;
    w.qy   = qy;
    w.desc = desc;
    send_word(w);
    filled_desc.push_back(desc);
  endtask

  // Hold off until every expected pixel is in and busy_o is low, then give
  // the pipe time to drain anything a trailing load may still be doing.
  task automatic settle_idle();
    @(negedge clk_i);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.pixels_due.size() != 0 || busy_o) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic set_enables(bit pri, bit sec);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= tap_pkg::CFG_PRIMARY_EN;
    cfg_wdata_i <= pri;
    @(negedge clk_i);
    cfg_idx_i   <= tap_pkg::CFG_SECONDARY_EN;
    cfg_wdata_i <= sec;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    ledger.set_enables(pri, sec);
  endtask

  // Random mix: draws over known windows (the largest share) with palette edits between,
  // a few fresh windows, and some noise (stray writes, dropped palette writes).
  task automatic random_mix(int quota);
    int           stop;
    int           pick;
    logic [15:0]  d;
    logic [15:0]  a;
    tap_pkg::op_e pal_op;
    stop = words_sent + quota;
    while (words_sent < stop) begin
      pick   = $urandom_range(0, 99);
      d      = filled_desc[$urandom_range(0, filled_desc.size() - 1)];
      pal_op = $urandom_range(0, 1) ? tap_pkg::OP_LOAD_SEC : tap_pkg::OP_LOAD_PRI;
      if (pick < 40) begin
        // same window, random bit 15 (shifted out) and random flips
        d = {1'($urandom), d[14:2], 2'($urandom)};
        draw_minitile(pick_tile(), 1'($urandom), 1'($urandom), d);
      end else if (pick < 44) begin
        draw_minitile(pick_tile(), 1'($urandom), 1'($urandom), 16'($urandom));
      end else if (pick < 60) begin
        a = 16'(3 * int'(hot_index()) + $urandom_range(0, 2));
        load_pal(pal_op, a, 8'($urandom));
      end else if (pick < 72) begin
        load_magenta(pal_op, hot_index(), $urandom_range(0, 4) == 0);
      end else if (pick < 82) begin
        a = {d[14:2], 3'b000} + 16'($urandom_range(0, 63));
        load_gfx(a, hot_index());
      end else if (pick < 90) begin
        load_gfx(16'($urandom), 8'($urandom));
      end else begin
        load_pal(pal_op, 16'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    ledger        = new();
    words_sent    = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    operation_i   = tap_pkg::OP_LOAD_GFX;
    address_i     = '0;
    load_value_i  = '0;
    tile_number_i = '0;
    quadrant_x_i  = 1'b0;
    quadrant_y_i  = 1'b0;
    descriptor_i  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = tap_pkg::CFG_PRIMARY_EN;
    cfg_wdata_i   = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // palette clearing pass runs here with busy_o high
    settle_idle();
    set_enables(1'b1, 1'b1);

    // Directed part.
    // index 1: primary magenta, so the secondary colour shows through
    load_magenta(tap_pkg::OP_LOAD_PRI, 8'd1, 1'b0);
    load_pal(tap_pkg::OP_LOAD_SEC, 16'd3, 8'hFF);
    load_pal(tap_pkg::OP_LOAD_SEC, 16'd4, 8'h01);
    load_pal(tap_pkg::OP_LOAD_SEC, 16'd5, 8'h80);
    // index 128: secondary magenta, so the primary colour is kept
    load_magenta(tap_pkg::OP_LOAD_SEC, 8'd128, 1'b0);
    load_pal(tap_pkg::OP_LOAD_PRI, 16'd384, 8'h3A);
    // last palette component, then writes past the end that must be dropped
    load_pal(tap_pkg::OP_LOAD_PRI, 16'd767, 8'hFF);
    load_pal(tap_pkg::OP_LOAD_PRI, 16'd768, 8'hFF);
    load_pal(tap_pkg::OP_LOAD_SEC, 16'hFFFF, 8'hFF);
    // graphics address extremes
    load_gfx(16'h0000, 8'h00);
    load_gfx(16'hFFFF, 8'hFF);
    // plain draw at the atlas origin
    draw_minitile(10'd0, 1'b0, 1'b0, 16'h0000);
    // far corner, both flips, window wraps past 0xFFFF back to 0
    draw_minitile(10'd1023, 1'b1, 1'b1, 16'hFFFF);
    // x flip only, bit 15 set (drops out of the base)
    draw_minitile(10'd15, 1'b1, 1'b0, 16'h8002);
    // y flip only, top window again
    draw_minitile(10'd1008, 1'b0, 1'b1, 16'h7FFD);
    // both flips, then no flips, over alternating base bits
    draw_minitile(10'd528, 1'b0, 1'b0, 16'h5557);
    draw_minitile(10'd257, 1'b1, 1'b0, 16'h2AA8);

    // Random phases, one enable setting each, sharing what is left of the
    // word budget; each phase boundary also lets the sender wait for every
    // outstanding pixel before carrying on.
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      set_enables(pri_plan[p], sec_plan[p]);
      random_mix((TOTAL_WORDS - words_sent) / (PHASES - p));
    end

    settle_idle();
    if (ledger.mismatches == 0 && ledger.pixels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- tile_atlas_pixel_renderer.f -----
+incdir+hw/rtl
hw/rtl/tap_pkg.sv
hw/rtl/tap_front.sv
hw/rtl/tap_queue.sv
hw/rtl/tap_back.sv
hw/rtl/tile_atlas_pixel_renderer.sv
tb/testbench.sv
